@@ hw/rtl/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Shared types, constants and round functions for the SHA-1 message hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_OFFSET  = 56;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam int unsigned DIGEST_WORDS = 5;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hefcdab89;
    localparam logic [31:0] H2_INIT = 32'h98badcfe;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
        logic       empty_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       put;        // write put_byte into the buffer word
        logic [7:0] put_byte;
        logic       count_add;  // advance bit count by one byte
        logic       load_w;     // start a compression: copy chain into a..e
        logic       round;      // run one round
        logic       add_chain;  // fold a..e into the chain
        logic       clear;      // return to reset values
    } t_cmd;

    typedef struct packed {
        logic [5:0]  pos;       // buffer offset
        logic [6:0]  rnd;       // round counter
        logic [63:0] bit_count;
    } t_status;

    function automatic logic [31:0] f_round(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (t < 7'd20) return (b & c) | (~b & d);
        else if (t < 7'd40) return b ^ c ^ d;
        else if (t < 7'd60) return (b & c) | (b & d) | (c & d);
        else return b ^ c ^ d;
    endfunction

    function automatic logic [31:0] k_round(input logic [6:0] t);
        if (t < 7'd20) return 32'h5a827999;
        else if (t < 7'd40) return 32'h6ed9eba1;
        else if (t < 7'd60) return 32'h8f1bbcdc;
        else return 32'hca62c1d6;
    endfunction

endpackage

@@ hw/rtl/sha1_datapath.sv @@
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer held as a 16-word schedule window, bit count, working
// variables and chaining words; one compression round per cycle.
// ----------------------------------------------------------------------------
module sha1_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1_pkg::t_cmd     i_cmd,
    output sha1_pkg::t_status  o_status,
    output logic [31:0]        o_chain [5]
);
    import sha1_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h [5];
    logic [63:0] r_bit_count;
    logic [5:0]  r_pos;
    logic [6:0]  r_rnd;

    logic [31:0] w_cur, w_new, tmp;
    logic [3:0]  widx;

    // The schedule window shifts each round; in the first 16 rounds the current word sits at index 0.
    assign w_new = {r_w[13][30:0] ^ r_w[8][30:0] ^ r_w[2][30:0] ^ r_w[0][30:0],
                    r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};
    assign w_cur = (r_rnd < 7'd16) ? r_w[0] : w_new;
    assign tmp   = {r_a[26:0], r_a[31:27]} + f_round(r_rnd, r_b, r_c, r_d) + r_e
                   + k_round(r_rnd) + w_cur;
    assign widx  = r_pos[5:2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            case (r_pos[1:0])
                2'd0:    r_w[widx][31:24] <= i_cmd.put_byte;
                2'd1:    r_w[widx][23:16] <= i_cmd.put_byte;
                2'd2:    r_w[widx][15:8]  <= i_cmd.put_byte;
                default: r_w[widx][7:0]   <= i_cmd.put_byte;
            endcase
        end
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_cur;
            r_a <= tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end else if (i_cmd.load_w) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_h[0] <= H0_INIT; r_h[1] <= H1_INIT; r_h[2] <= H2_INIT;
            r_h[3] <= H3_INIT; r_h[4] <= H4_INIT;
            r_bit_count <= '0;
            r_pos <= '0;
            r_rnd <= '0;
        end else begin
            if (i_cmd.put) r_pos <= r_pos + 6'd1;
            if (i_cmd.count_add) r_bit_count <= r_bit_count + 64'd8;
            if (i_cmd.load_w) r_rnd <= '0;
            else if (i_cmd.round) r_rnd <= r_rnd + 7'd1;
            if (i_cmd.add_chain) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b; r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d; r_h[4] <= r_h[4] + r_e;
            end
        end
    end

    assign o_status.pos       = r_pos;
    assign o_status.rnd       = r_rnd;
    assign o_status.bit_count = r_bit_count;
    assign o_chain = r_h;
endmodule

@@ hw/rtl/sha1_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sha1_pkg::t_in_item  i_item,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [2:0]          o_word_sel,
    input  sha1_pkg::t_status   i_status,
    output sha1_pkg::t_cmd      o_cmd
);
    import sha1_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;     // where to go after a compression
    logic [2:0] r_lenb, n_lenb;  // length byte counter, 7 down to 0
    logic [2:0] r_word, n_word;
    logic [63:0] r_len, n_len;
    logic        r_zero, n_zero; // the 0x80 byte is written, zeros follow
    logic        acc;

    assign acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_lenb  <= '0;
            r_word  <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_lenb  <= n_lenb;
            r_word  <= n_word;
            r_zero  <= n_zero;
        end
        r_len <= n_len;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_lenb  = r_lenb;
        n_word  = r_word;
        n_len   = r_len;
        n_zero  = r_zero;
        case (r_state)
            ST_IDLE: begin
                n_zero = 1'b0;
                if (acc) begin
                    if (!i_item.empty_message && i_status.pos == 6'd63) begin
                        n_state = ST_ROUND;
                        n_ret   = i_item.is_last ? ST_PAD : ST_IDLE;
                    end else if (i_item.is_last) begin
                        n_state = ST_PAD;
                    end
                    n_len = i_item.empty_message ? i_status.bit_count
                                                 : i_status.bit_count + 64'd8;
                end
            end
            ST_PAD: begin
                // The 0x80 byte, then zeros until the length offset. When the
                // block fills first, it is compressed and zero fill resumes.
                n_zero = 1'b1;
                if (i_status.pos == 6'd63) begin
                    n_state = ST_ROUND;
                    n_ret   = ST_PAD;
                end else if (i_status.pos == 6'(LEN_OFFSET - 1)) begin
                    n_state = ST_LEN;
                end
                n_lenb = 3'd7;
            end
            ST_LEN: begin
                if (r_lenb == 3'd0) begin
                    n_state = ST_ROUND;
                    n_ret   = ST_OUT;
                    n_word  = '0;
                end else begin
                    n_lenb = r_lenb - 3'd1;
                end
            end
            ST_ROUND: begin
                if (i_status.rnd == 7'd80) n_state = ST_FINAL;
            end
            ST_FINAL: begin
                n_state = r_ret;
                n_lenb  = 3'd7;
                n_word  = '0;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    if (r_word == 3'(DIGEST_WORDS - 1)) n_state = ST_IDLE;
                    else n_word = r_word + 3'd1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (acc && !i_item.empty_message) begin
                    o_cmd.put       = 1'b1;
                    o_cmd.put_byte  = i_item.data_byte;
                    o_cmd.count_add = 1'b1;
                end
                o_cmd.load_w = acc && !i_item.empty_message && i_status.pos == 6'd63;
            end
            ST_PAD: begin
                o_cmd.put      = 1'b1;
                o_cmd.put_byte = r_zero ? 8'h00 : PAD_BYTE;
                o_cmd.load_w   = i_status.pos == 6'd63;
            end
            ST_LEN: begin
                o_cmd.put      = 1'b1;
                o_cmd.put_byte = r_len[{r_lenb, 3'b000} +: 8];
                o_cmd.load_w   = r_lenb == 3'd0;
            end
            ST_ROUND: o_cmd.round = i_status.rnd != 7'd80;
            ST_FINAL: o_cmd.add_chain = 1'b1;
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.clear = i_out_ready && r_word == 3'(DIGEST_WORDS - 1);
            end
            default: ;
        endcase
    end

    assign o_word_sel = r_word;
endmodule

@@ hw/rtl/sha1_message_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message hasher
// Byte-serial SHA-1 (FIPS 180) with built-in padding and digest readout.
// ----------------------------------------------------------------------------
// The block takes one message byte per input transaction. A byte that
// completes a 64-byte block starts a compression (80 rounds in one shared
// round unit, a step that ends the round count and one chain update; the load
// happens in the cycle that takes the byte) before the next byte is taken. A
// transaction marked last starts padding, one padding byte per cycle (held
// while a filled block is compressed) up to offset 56, one or two compressions
// and eight length bytes, then presents the five digest words H0..H4 as five
// output transactions, after which the state returns to reset values. An item
// with the empty mark and no last mark is accepted and ignored. The buffer is
// the 16-word schedule window itself, so no separate byte memory exists.
// Throughput is bounded by the round unit, as no byte is taken while a block
// is compressed.
module sha1_message_hasher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sha1_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sha1_pkg::t_out_item  o_data
);
    import sha1_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [31:0] chain [5];
    logic [2:0]  word_sel;

    sha1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_data),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_word_sel  (word_sel),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sha1_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .o_chain  (chain)
    );

    always_comb begin
        case (word_sel)
            3'd0:    o_data.digest_word = chain[0];
            3'd1:    o_data.digest_word = chain[1];
            3'd2:    o_data.digest_word = chain[2];
            3'd3:    o_data.digest_word = chain[3];
            default: o_data.digest_word = chain[4];
        endcase
    end
    assign o_data.word_index = word_sel;
    assign o_data.last_word  = word_sel == 3'(DIGEST_WORDS - 1);

    // Input is never taken while a digest is presented.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(o_valid && o_ready))
        else $error("input accepted during digest output");
    // Word index stays in range while presented.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> word_sel <= 3'd4)
        else $error("digest word index out of range");
    // After the final word is taken the bit count is back at zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.last_word) |=> status.bit_count == 64'd0)
        else $error("state not cleared after digest");
endmodule
